### rtl/core/sfp_pkg.sv
// Shared constants, word types and controller codes of the spatial footprint prefetcher.
package sfp_pkg;

  localparam int ADDR_W          = 48;
  localparam int REGION_BLOCKS   = 32;
  localparam int BLOCK_BYTES     = 64;
  localparam int ACTIVE_ENTRIES  = 16;
  localparam int PATTERN_ENTRIES = 1024;
  localparam int PATTERN_WAYS    = 8;
  localparam int STAMP_W         = 32;

  localparam int OFF_W   = $clog2(REGION_BLOCKS);
  localparam int BOFF_W  = $clog2(BLOCK_BYTES);
  localparam int PAGE_W  = ADDR_W - OFF_W - BOFF_W;
  localparam int AIDX_W  = $clog2(ACTIVE_ENTRIES);
  localparam int WAY_W   = $clog2(PATTERN_WAYS);
  localparam int NUM_SETS = (PATTERN_ENTRIES / PATTERN_WAYS) > 0 ?
                            (PATTERN_ENTRIES / PATTERN_WAYS) : 1;
  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int SLOT_W  = SET_W + WAY_W;
  localparam int VOTE_W  = $clog2(PATTERN_WAYS + 1);
  localparam int THR_NUM = 20;
  localparam int THR_DEN = 100;

  typedef struct packed {
    logic              has_pc;
    logic [ADDR_W-1:0] access_pc;
    logic [ADDR_W-1:0] access_addr;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefetch_addr;
    logic              last_of_run;
  } out_word_t;

  typedef struct packed {
    logic                     valid;
    logic [ADDR_W-1:0]        pc;
    logic [PAGE_W-1:0]        page;
    logic [OFF_W-1:0]         off;
    logic [REGION_BLOCKS-1:0] fp;
  } pat_entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_ADECIDE,
    S_VREAD,
    S_VCHECK,
    S_VWRITE,
    S_PREAD,
    S_PCHECK,
    S_REFRESH,
    S_PRED,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic idle;
    logic clear_step;
    logic load;
    logic ascan_step;
    logic a_commit;
    logic v_read;
    logic v_check;
    logic v_commit;
    logic p_read;
    logic p_check;
    logic refresh_step;
    logic pred_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic ascan_last;
    logic a_resolved;
    logic way_last;
    logic p_exact;
    logic refresh_last;
    logic pend_any;
  } status_t;

endpackage

### rtl/core/spatial_footprint_prefetcher_unit.sv
// Top level of the spatial footprint prefetcher: controller plus datapath.
//
// Input channel: one word per cache access (has_pc, access_pc, access_addr),
// taken when in_valid is high and in_stall is low. A word with has_pc low is
// taken and dropped. Output channel: one prefetch address per word, with
// last_of_run set on the final address caused by an access; an access may
// cause no output word at all.
// Per access: the word is taken, the active table is scanned entry by entry, and
// a decision is made; a region retired to the pattern table first has the ways
// of its set read one at a time to choose a victim. The ways of the access's set
// are read one at a time (up to 16 way reads in all, one memory read port), the
// stamps are updated way by way, the prediction is formed, and one word per cycle
// is emitted unless the output stalls; in_stall stays high all through.
// The output word sits in a register, so the next access is taken while the
// last word still waits. A stalled output holds its word and the emitting
// sequence waits.
// After reset the 1024 pattern table entries are cleared one entry a cycle;
// in_stall stays high until that pass finishes.
module spatial_footprint_prefetcher_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfp_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfp_pkg::out_word_t  out_data
);

  sfp_pkg::cmd_t    cmd;
  sfp_pkg::status_t st;

  assign in_stall = !cmd.idle;

  sfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_has_pc (in_data.has_pc),
    .st        (st),
    .cmd       (cmd)
  );

  sfp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/sfp_ctrl.sv
// Sequencing state machine of the spatial footprint prefetcher.
module sfp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_has_pc,
  input  sfp_pkg::status_t  st,
  output sfp_pkg::cmd_t     cmd
);

  sfp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfp_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sfp_pkg::S_CLEAR:   if (st.clear_done) state_next = sfp_pkg::S_IDLE;
      sfp_pkg::S_IDLE:    if (in_valid && in_has_pc) state_next = sfp_pkg::S_ASCAN;
      sfp_pkg::S_ASCAN:   if (st.ascan_last) state_next = sfp_pkg::S_ADECIDE;
      sfp_pkg::S_ADECIDE: begin
        state_next = st.a_resolved ? sfp_pkg::S_PREAD : sfp_pkg::S_VREAD;
      end
      sfp_pkg::S_VREAD:   state_next = sfp_pkg::S_VCHECK;
      sfp_pkg::S_VCHECK: begin
        state_next = st.way_last ? sfp_pkg::S_VWRITE : sfp_pkg::S_VREAD;
      end
      sfp_pkg::S_VWRITE:  state_next = sfp_pkg::S_PREAD;
      sfp_pkg::S_PREAD:   state_next = sfp_pkg::S_PCHECK;
      sfp_pkg::S_PCHECK: begin
        state_next = (st.p_exact || st.way_last) ? sfp_pkg::S_REFRESH : sfp_pkg::S_PREAD;
      end
      sfp_pkg::S_REFRESH: if (st.refresh_last) state_next = sfp_pkg::S_PRED;
      sfp_pkg::S_PRED:    state_next = sfp_pkg::S_EMIT;
      sfp_pkg::S_EMIT:    if (!st.pend_any) state_next = sfp_pkg::S_IDLE;
      default:            state_next = sfp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.idle         = (state == sfp_pkg::S_IDLE);
    cmd.clear_step   = (state == sfp_pkg::S_CLEAR);
    cmd.load         = (state == sfp_pkg::S_IDLE) && in_valid && in_has_pc;
    cmd.ascan_step   = (state == sfp_pkg::S_ASCAN);
    cmd.a_commit     = (state == sfp_pkg::S_ADECIDE) && st.a_resolved;
    cmd.v_read       = (state == sfp_pkg::S_VREAD);
    cmd.v_check      = (state == sfp_pkg::S_VCHECK);
    cmd.v_commit     = (state == sfp_pkg::S_VWRITE);
    cmd.p_read       = (state == sfp_pkg::S_PREAD);
    cmd.p_check      = (state == sfp_pkg::S_PCHECK);
    cmd.refresh_step = (state == sfp_pkg::S_REFRESH);
    cmd.pred_load    = (state == sfp_pkg::S_PRED);
    cmd.emit         = (state == sfp_pkg::S_EMIT);
  end

endmodule

### rtl/core/sfp_datapath.sv
// Region tables, pattern memories, voting and prefetch word output register.
module sfp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sfp_pkg::cmd_t       cmd,
  input  sfp_pkg::in_word_t   in_data,
  output sfp_pkg::status_t    st,
  output logic                out_valid,
  input  logic                out_stall,
  output sfp_pkg::out_word_t  out_data
);

  localparam int AE = sfp_pkg::ACTIVE_ENTRIES;
  localparam int PW = sfp_pkg::PATTERN_WAYS;
  localparam int RB = sfp_pkg::REGION_BLOCKS;

  function automatic logic [sfp_pkg::VOTE_W-1:0] thr_of(input logic [sfp_pkg::VOTE_W-1:0] n);
    logic [sfp_pkg::VOTE_W-1:0] t;
    t = '0;
    for (int k = 1; k <= PW; k++) begin
      if (k * sfp_pkg::THR_DEN <= int'(n) * sfp_pkg::THR_NUM) t = t + 1'b1;
    end
    if (t == '0) t = sfp_pkg::VOTE_W'(1);
    return t;
  endfunction

  function automatic logic [sfp_pkg::OFF_W-1:0] low_idx(input logic [RB-1:0] v);
    logic [sfp_pkg::OFF_W-1:0] r;
    r = '0;
    for (int b = RB - 1; b >= 0; b--) begin
      if (v[b]) r = sfp_pkg::OFF_W'(b);
    end
    return r;
  endfunction

  // current access
  logic [sfp_pkg::ADDR_W-1:0]  cur_pc;
  logic [sfp_pkg::PAGE_W-1:0]  cur_page;
  logic [sfp_pkg::OFF_W-1:0]   cur_off;
  logic [sfp_pkg::STAMP_W-1:0] access_counter;
  logic [sfp_pkg::STAMP_W-1:0] stamp;

  // active table
  logic [AE-1:0]                   act_valid;
  logic [sfp_pkg::PAGE_W-1:0]      act_page [AE];
  logic [sfp_pkg::ADDR_W-1:0]      act_pc   [AE];
  logic [sfp_pkg::OFF_W-1:0]       act_off  [AE];
  logic [RB-1:0]                   act_fp   [AE];
  logic [sfp_pkg::STAMP_W-1:0]     act_stamp[AE];

  logic [sfp_pkg::AIDX_W-1:0]  aidx;
  logic                        hit_f, inv_f;
  logic [sfp_pkg::AIDX_W-1:0]  hit_idx, inv_idx, min_idx;
  logic [sfp_pkg::STAMP_W-1:0] min_stamp;

  // pattern memories
  sfp_pkg::pat_entry_t          pmem [sfp_pkg::NUM_SETS * PW];
  logic [sfp_pkg::STAMP_W-1:0]  smem [sfp_pkg::NUM_SETS * PW];
  sfp_pkg::pat_entry_t          rd_entry;
  logic [sfp_pkg::STAMP_W-1:0]  rd_stamp;
  logic [sfp_pkg::SLOT_W-1:0]   clr;
  logic [sfp_pkg::WAY_W-1:0]    way, rway;

  logic                         vinv_f;
  logic [sfp_pkg::WAY_W-1:0]    vway;
  logic [sfp_pkg::STAMP_W-1:0]  vbest;

  logic                         exact_f;
  logic [RB-1:0]                exact_fp;
  logic [PW-1:0]                upd_mask;
  logic [sfp_pkg::VOTE_W-1:0]   nshort;
  logic [sfp_pkg::VOTE_W-1:0]   votes [RB];
  logic [RB-1:0]                pend;

  logic [sfp_pkg::SET_W-1:0]    v_set, p_set;
  logic [sfp_pkg::SLOT_W-1:0]   raddr;
  logic                         p_match, p_exact_now, out_free;
  logic [RB-1:0]                vote_fp, pend_low;
  logic [sfp_pkg::VOTE_W-1:0]   thr;

  assign v_set = act_pc[min_idx][sfp_pkg::SET_W:1] ^ sfp_pkg::SET_W'(act_off[min_idx]);
  assign p_set = cur_pc[sfp_pkg::SET_W:1] ^ sfp_pkg::SET_W'(cur_off);
  assign raddr = cmd.v_read ? {v_set, way} : {p_set, way};

  assign p_match     = rd_entry.valid && (rd_entry.pc == cur_pc) && (rd_entry.off == cur_off);
  assign p_exact_now = p_match && (rd_entry.page == cur_page);
  assign out_free    = !out_valid || !out_stall;
  assign thr         = thr_of(nshort);
  assign pend_low    = pend & (~pend + 1'b1);

  always_comb begin
    for (int b = 0; b < RB; b++) vote_fp[b] = (votes[b] >= thr);
  end

  always_comb begin
    st              = '0;
    st.clear_done   = (clr == '1);
    st.ascan_last   = (aidx == sfp_pkg::AIDX_W'(AE - 1));
    st.a_resolved   = hit_f || inv_f;
    st.way_last     = (way == sfp_pkg::WAY_W'(PW - 1));
    st.p_exact      = cmd.p_check && p_exact_now;
    st.refresh_last = (rway == sfp_pkg::WAY_W'(PW - 1));
    st.pend_any     = (pend != '0);
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      pmem[clr] <= '0;
    end else if (cmd.v_commit) begin
      pmem[{v_set, vway}] <= '{valid: 1'b1, pc: act_pc[min_idx], page: act_page[min_idx],
                               off: act_off[min_idx], fp: act_fp[min_idx]};
    end
    if (cmd.v_commit) begin
      smem[{v_set, vway}] <= stamp;
    end else if (cmd.refresh_step && upd_mask[rway]) begin
      smem[{p_set, rway}] <= stamp;
    end
    if (cmd.v_read || cmd.p_read) begin
      rd_entry <= pmem[raddr];
      rd_stamp <= smem[raddr];
    end
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      clr            <= '0;
      access_counter <= '0;
      act_valid      <= '0;
      out_valid      <= 1'b0;
      pend           <= '0;
    end else begin
      if (cmd.clear_step && clr != '1) clr <= clr + 1'b1;
      if (cmd.load) access_counter <= access_counter + 1'b1;
      if (cmd.a_commit && !hit_f) act_valid[inv_idx] <= 1'b1;
      if (cmd.pred_load) begin
        pend <= (exact_f ? exact_fp : (nshort != '0 ? vote_fp : '0)) &
                ~(RB'(1) << cur_off);
      end else if (cmd.emit && pend != '0 && out_free) begin
        pend <= pend & ~pend_low;
      end
      if (cmd.emit && pend != '0 && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_pc   <= in_data.access_pc;
      cur_page <= in_data.access_addr[sfp_pkg::ADDR_W-1 -: sfp_pkg::PAGE_W];
      cur_off  <= in_data.access_addr[sfp_pkg::BOFF_W +: sfp_pkg::OFF_W];
      stamp    <= access_counter + 1'b1;
      aidx     <= '0;
      hit_f    <= 1'b0;
      inv_f    <= 1'b0;
      way      <= '0;
      vinv_f   <= 1'b0;
    end
    if (cmd.ascan_step) begin
      if (act_valid[aidx] && act_page[aidx] == cur_page && !hit_f) begin
        hit_f   <= 1'b1;
        hit_idx <= aidx;
      end
      if (!act_valid[aidx] && !inv_f) begin
        inv_f   <= 1'b1;
        inv_idx <= aidx;
      end
      if (aidx == '0 || act_stamp[aidx] < min_stamp) begin
        min_stamp <= act_stamp[aidx];
        min_idx   <= aidx;
      end
      aidx <= aidx + 1'b1;
    end
    if (cmd.a_commit) begin
      if (hit_f) begin
        act_fp[hit_idx]    <= act_fp[hit_idx] | (RB'(1) << cur_off);
        act_stamp[hit_idx] <= stamp;
      end else begin
        act_page[inv_idx]  <= cur_page;
        act_pc[inv_idx]    <= cur_pc;
        act_off[inv_idx]   <= cur_off;
        act_fp[inv_idx]    <= RB'(1) << cur_off;
        act_stamp[inv_idx] <= stamp;
      end
    end
    if (cmd.v_check) begin
      if (!vinv_f) begin
        if (!rd_entry.valid) begin
          vinv_f <= 1'b1;
          vway   <= way;
        end else if (way == '0 || rd_stamp < vbest) begin
          vbest <= rd_stamp;
          vway  <= way;
        end
      end
      way <= way + 1'b1;
    end
    if (cmd.v_commit) begin
      act_page[min_idx]  <= cur_page;
      act_pc[min_idx]    <= cur_pc;
      act_off[min_idx]   <= cur_off;
      act_fp[min_idx]    <= RB'(1) << cur_off;
      act_stamp[min_idx] <= stamp;
    end
    if (cmd.a_commit || cmd.v_commit) begin
      way      <= '0;
      rway     <= '0;
      exact_f  <= 1'b0;
      upd_mask <= '0;
      nshort   <= '0;
      for (int b = 0; b < RB; b++) votes[b] <= '0;
    end
    if (cmd.p_check) begin
      if (p_exact_now) begin
        exact_f  <= 1'b1;
        exact_fp <= rd_entry.fp;
        upd_mask <= PW'(1) << way;
      end else if (p_match) begin
        upd_mask[way] <= 1'b1;
        nshort        <= nshort + 1'b1;
        for (int b = 0; b < RB; b++) begin
          votes[b] <= votes[b] + sfp_pkg::VOTE_W'(rd_entry.fp[b]);
        end
      end
      way <= way + 1'b1;
    end
    if (cmd.refresh_step) rway <= rway + 1'b1;
    if (cmd.emit && pend != '0 && out_free) begin
      out_data.prefetch_addr <= {cur_page, low_idx(pend), sfp_pkg::BOFF_W'(0)};
      out_data.last_of_run   <= ((pend & ~pend_low) == '0);
    end
  end

endmodule

### tb/tb.sv
// Self-checking testbench for the spatial footprint prefetcher unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REGION_SHIFT = sfp_pkg::OFF_W + sfp_pkg::BOFF_W;
  localparam int SLOTS        = sfp_pkg::NUM_SETS * sfp_pkg::PATTERN_WAYS;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  sfp_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  sfp_pkg::out_word_t out_data;

  spatial_footprint_prefetcher_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sfp_pkg::in_word_t  access_q[$];
  sfp_pkg::out_word_t prefetch_q[$];
  int                 errors = 0;

  logic                              act_valid [sfp_pkg::ACTIVE_ENTRIES];
  logic [sfp_pkg::ADDR_W-1:0]        act_page  [sfp_pkg::ACTIVE_ENTRIES];
  logic [sfp_pkg::ADDR_W-1:0]        act_pc    [sfp_pkg::ACTIVE_ENTRIES];
  logic [sfp_pkg::OFF_W-1:0]         act_off   [sfp_pkg::ACTIVE_ENTRIES];
  logic [sfp_pkg::REGION_BLOCKS-1:0] act_fp    [sfp_pkg::ACTIVE_ENTRIES];
  logic [sfp_pkg::STAMP_W-1:0]       act_stamp [sfp_pkg::ACTIVE_ENTRIES];
  logic                              pat_valid [SLOTS];
  logic [sfp_pkg::ADDR_W-1:0]        pat_pc    [SLOTS];
  logic [sfp_pkg::ADDR_W-1:0]        pat_page  [SLOTS];
  logic [sfp_pkg::OFF_W-1:0]         pat_off   [SLOTS];
  logic [sfp_pkg::REGION_BLOCKS-1:0] pat_fp    [SLOTS];
  logic [sfp_pkg::STAMP_W-1:0]       pat_stamp [SLOTS];
  logic [sfp_pkg::STAMP_W-1:0]       access_count;

  function automatic int set_base(logic [sfp_pkg::ADDR_W-1:0] pc,
                                  logic [sfp_pkg::OFF_W-1:0] off);
    return int'(((pc >> 1) ^ sfp_pkg::ADDR_W'(off)) % sfp_pkg::NUM_SETS) *
           sfp_pkg::PATTERN_WAYS;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic add_access(sfp_pkg::in_word_t w);
    access_q.insert(access_q.size(), w);
  endtask

  task automatic predict_prefetches(sfp_pkg::in_word_t w);
    logic [sfp_pkg::ADDR_W-1:0]        pc, page;
    logic [sfp_pkg::OFF_W-1:0]         off;
    logic [sfp_pkg::STAMP_W-1:0]       stamp;
    logic [sfp_pkg::REGION_BLOCKS-1:0] fp;
    int hit, slot, v, base, way, ex, ns, thr, votes, n;
    int shortlist[sfp_pkg::PATTERN_WAYS];
    logic [sfp_pkg::ADDR_W-1:0] addrs[$];
    sfp_pkg::out_word_t o;
    if (!w.has_pc) return;
    pc = w.access_pc;
    page = (w.access_addr >> REGION_SHIFT) << REGION_SHIFT;
    off = w.access_addr[REGION_SHIFT-1:sfp_pkg::BOFF_W];
    access_count++;
    stamp = access_count;
    hit = -1;
    for (int i = 0; i < sfp_pkg::ACTIVE_ENTRIES; i++)
      if (hit < 0 && act_valid[i] && act_page[i] == page) hit = i;
    if (hit >= 0) begin
      act_fp[hit][off] = 1'b1;
      act_stamp[hit] = stamp;
    end else begin
      slot = -1;
      for (int i = 0; i < sfp_pkg::ACTIVE_ENTRIES; i++)
        if (slot < 0 && !act_valid[i]) slot = i;
      if (slot < 0) begin
        v = 0;
        for (int i = 1; i < sfp_pkg::ACTIVE_ENTRIES; i++)
          if (act_stamp[i] < act_stamp[v]) v = i;
        base = set_base(act_pc[v], act_off[v]);
        way = -1;
        for (int x = 0; x < sfp_pkg::PATTERN_WAYS; x++)
          if (way < 0 && !pat_valid[base+x]) way = x;
        if (way < 0) begin
          way = 0;
          for (int x = 1; x < sfp_pkg::PATTERN_WAYS; x++)
            if (pat_stamp[base+x] < pat_stamp[base+way]) way = x;
        end
        pat_valid[base+way] = 1'b1;
        pat_pc[base+way]    = act_pc[v];
        pat_page[base+way]  = act_page[v];
        pat_off[base+way]   = act_off[v];
        pat_fp[base+way]    = act_fp[v];
        pat_stamp[base+way] = stamp;
        slot = v;
      end
      act_valid[slot] = 1'b1;
      act_page[slot]  = page;
      act_pc[slot]    = pc;
      act_off[slot]   = off;
      act_fp[slot]    = '0;
      act_fp[slot][off] = 1'b1;
      act_stamp[slot] = stamp;
    end
    base = set_base(pc, off);
    ex = -1;
    ns = 0;
    for (int x = 0; x < sfp_pkg::PATTERN_WAYS; x++)
      if (ex < 0 && pat_valid[base+x] && pat_pc[base+x] == pc && pat_off[base+x] == off) begin
        if (pat_page[base+x] == page) ex = base + x;
        else shortlist[ns++] = base + x;
      end
    fp = '0;
    if (ex >= 0) begin
      fp = pat_fp[ex];
      pat_stamp[ex] = stamp;
    end else if (ns > 0) begin
      thr = (ns * sfp_pkg::THR_NUM) / sfp_pkg::THR_DEN;
      if (thr == 0) thr = 1;
      for (int b = 0; b < sfp_pkg::REGION_BLOCKS; b++) begin
        votes = 0;
        for (int i = 0; i < ns; i++) if (pat_fp[shortlist[i]][b]) votes++;
        if (votes >= thr) fp[b] = 1'b1;
      end
      for (int i = 0; i < ns; i++) pat_stamp[shortlist[i]] = stamp;
    end else return;
    for (int b = 0; b < sfp_pkg::REGION_BLOCKS; b++)
      if (fp[b] && b != off)
        addrs.insert(addrs.size(), page + sfp_pkg::ADDR_W'(b * sfp_pkg::BLOCK_BYTES));
    n = addrs.size();
    for (int k = 0; k < n; k++) begin
      o.prefetch_addr = addrs[k];
      o.last_of_run = (k == n - 1);
      prefetch_q.insert(prefetch_q.size(), o);
    end
  endtask

  // driver
  logic in_taken = 0;
  logic out_taken = 0;
  int   in_gap = 0;
  int   out_hold = 0;
  logic burst = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (access_q.size() > 0) begin
        in_data <= access_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 15) == 0) burst = !burst;
        in_gap = burst ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    sfp_pkg::out_word_t want;
    in_taken = 0;
    out_taken = 0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        out_taken = 1;
        out_hold = burst ? 0 : $urandom_range(0, 7);
        if (prefetch_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data));
        end else begin
          want = prefetch_q.pop_front();
          if (out_data.prefetch_addr !== want.prefetch_addr)
            report_mismatch($sformatf("prefetch_addr %h, want %h",
                                      out_data.prefetch_addr, want.prefetch_addr));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b at %h",
                                      out_data.last_of_run, want.last_of_run,
                                      want.prefetch_addr));
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1;
        predict_prefetches(in_data);
      end
    end
  end

  function automatic sfp_pkg::in_word_t make_access(logic has_pc,
                                                    logic [sfp_pkg::ADDR_W-1:0] pc,
                                                    logic [sfp_pkg::ADDR_W-1:0] addr);
    sfp_pkg::in_word_t w;
    w.has_pc = has_pc;
    w.access_pc = pc;
    w.access_addr = addr;
    return w;
  endfunction

  function automatic logic [sfp_pkg::ADDR_W-1:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [sfp_pkg::ADDR_W-1:0] pcs[4];
    logic [sfp_pkg::ADDR_W-1:0] regions[40];
    logic [sfp_pkg::OFF_W-1:0]  offs[4];
    logic [sfp_pkg::ADDR_W-1:0] pc, dir_pc, dir_base;
    int r;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    access_count = '0;
    for (int i = 0; i < sfp_pkg::ACTIVE_ENTRIES; i++) act_valid[i] = 1'b0;
    for (int i = 0; i < SLOTS; i++) pat_valid[i] = 1'b0;

    dir_pc = 48'h0000_1234_5678;
    dir_base = 48'h0000_1000_0000;
    add_access(make_access(1'b0, '1, '1));
    add_access(make_access(1'b1, '0, '0));
    add_access(make_access(1'b1, '1, '1));
    add_access(make_access(1'b1, '1, 48'hFFFF_FFFF_F800));
    add_access(make_access(1'b1, dir_pc, dir_base + 3*sfp_pkg::BLOCK_BYTES));
    add_access(make_access(1'b1, dir_pc, dir_base + 7*sfp_pkg::BLOCK_BYTES + 5));
    for (int k = 1; k <= 18; k++)
      add_access(make_access(1'b1, dir_pc,
                 dir_base + sfp_pkg::ADDR_W'(k * sfp_pkg::REGION_BLOCKS * sfp_pkg::BLOCK_BYTES) +
                 3*sfp_pkg::BLOCK_BYTES));
    add_access(make_access(1'b1, dir_pc, dir_base + 3*sfp_pkg::BLOCK_BYTES));

    for (int i = 0; i < 4; i++) begin
      pcs[i] = rand48();
      offs[i] = sfp_pkg::OFF_W'($urandom);
    end
    offs[0] = '0;
    offs[1] = '1;
    for (int i = 0; i < 40; i++) regions[i] = (rand48() >> REGION_SHIFT) << REGION_SHIFT;
    r = 0;
    while (r < 175) begin
      case ($urandom_range(0, 19))
        0: add_access(make_access(1'b0, rand48(), rand48()));
        1, 2: begin
          add_access(make_access(1'b1, rand48(), rand48()));
          r++;
        end
        default: begin
          pc = pcs[$urandom_range(0, 3)];
          add_access(make_access(1'b1, pc,
            regions[$urandom_range(0, 39)] |
            (sfp_pkg::ADDR_W'($urandom_range(0, 1) ? offs[$urandom_range(0, 3)] :
                                                     sfp_pkg::OFF_W'($urandom))
              << sfp_pkg::BOFF_W) |
            sfp_pkg::ADDR_W'($urandom_range(0, sfp_pkg::BLOCK_BYTES - 1))));
          r++;
        end
      endcase
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    while (access_q.size() > 0 || (in_valid && !in_taken)) @(posedge clk);
    while (prefetch_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (prefetch_q.size() > 0) report_mismatch("expected words never arrived");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
